/* src/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned Capacity  = 16;
  localparam int unsigned PrioBits  = 16;
  localparam int unsigned TagBits   = 32;
  localparam int unsigned CountBits = 5;

  typedef enum logic [1:0] {
    ModeEnqueue = 2'd0,
    ModePop     = 2'd1,
    ModeRemove  = 2'd2,
    ModePeek    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusEmpty    = 2'd1,
    StatusFull     = 2'd2,
    StatusNotFound = 2'd3
  } status_e;

  // broadcast to every cell of the row
  typedef struct packed {
    logic  en;
    mode_e mode;
  } cell_ctrl_t;

endpackage

/* src/spq_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_in_if
// request channel: mode, tag and priority of one queue operation
// ----------------------------------------------------------------------------
interface spq_in_if #(
  parameter int unsigned TAG_BITS  = spq_pkg::TagBits,
  parameter int unsigned PRIO_BITS = spq_pkg::PrioBits
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [TAG_BITS-1:0]         tag;
  logic signed [PRIO_BITS-1:0] priority_req;

  modport source (output valid, output mode, output tag, output priority_req, input ready);
  modport sink   (input valid, input mode, input tag, input priority_req, output ready);
endinterface

/* src/spq_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_out_if
// response channel: returned entry, status and entry count
// ----------------------------------------------------------------------------
interface spq_out_if #(
  parameter int unsigned TAG_BITS  = spq_pkg::TagBits,
  parameter int unsigned PRIO_BITS = spq_pkg::PrioBits
);
  logic                            valid;
  logic                            ready;
  logic [TAG_BITS-1:0]             out_tag;
  logic signed [PRIO_BITS-1:0]     out_priority;
  logic [1:0]                      status;
  logic [spq_pkg::CountBits-1:0]   count;

  modport source (output valid, output out_tag, output out_priority, output status,
                  output count, input ready);
  modport sink   (input valid, input out_tag, input out_priority, input status,
                  input count, output ready);
endinterface

/* src/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue of tagged entries, sorted by descending priority
// ----------------------------------------------------------------------------
// The queue is a row of CAPACITY cells, head in cell 0. Every cell compares
// its entry with the request at once and loads the new entry, its left or
// its right neighbor, so enqueue, pop, remove by tag and peek each finish as
// the request is taken: one request is taken per cycle and its response is
// registered, valid the cycle after the request transfer. A new request is
// taken while the response register is empty or is being drained. The
// critical path is the tag compare of every cell followed by a log2(CAPACITY)
// deep prefix over the match flags that picks the first matching entry.
// Entries of equal priority leave in arrival order; an enqueue into a full
// queue is dropped with status full and the unchanged head. The reported
// count wraps modulo 32.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int unsigned CAPACITY  = spq_pkg::Capacity,
  parameter int unsigned PRIO_BITS = spq_pkg::PrioBits,
  parameter int unsigned TAG_BITS  = spq_pkg::TagBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  spq_in_if.sink         req_i,
  spq_out_if.source      rsp_o
);

  localparam int unsigned OccBits = $clog2(CAPACITY + 1);
  localparam int unsigned CntBits = spq_pkg::CountBits;

  logic                        accept;
  spq_pkg::mode_e              mode;
  spq_pkg::cell_ctrl_t         ctrl;
  logic [TAG_BITS-1:0]         req_tag;
  logic signed [PRIO_BITS-1:0] req_prio;

  logic                        cell_valid [CAPACITY];
  logic [TAG_BITS-1:0]         cell_tag   [CAPACITY];
  logic signed [PRIO_BITS-1:0] cell_prio  [CAPACITY];
  logic [CAPACITY-1:0]         cell_ge;
  logic [CAPACITY-1:0]         cell_match;
  logic [CAPACITY-1:0]         del;
  logic [CAPACITY-1:0]         first;

  logic [OccBits-1:0]          occ_q, occ_d;
  logic                        full, empty, found;
  logic signed [PRIO_BITS-1:0] rm_prio;

  logic                        rsp_valid_q;
  logic [TAG_BITS-1:0]         rsp_tag_q, rsp_tag_d;
  logic signed [PRIO_BITS-1:0] rsp_prio_q, rsp_prio_d;
  spq_pkg::status_e            rsp_status_q, rsp_status_d;
  logic [CntBits-1:0]          rsp_count_q;
  logic [OccBits+CntBits-1:0]  occ_ext;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign mode        = spq_pkg::mode_e'(req_i.mode);
  assign req_tag     = req_i.tag;
  assign req_prio    = req_i.priority_req;

  assign full  = (occ_q == OccBits'(CAPACITY));
  assign empty = (occ_q == '0);
  assign found = del[CAPACITY-1];

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                        lv, rv, lge;
    logic [TAG_BITS-1:0]         lt, rt;
    logic signed [PRIO_BITS-1:0] lp, rp;

    if (i == 0) begin : g_head
      assign lv  = 1'b0;
      assign lt  = '0;
      assign lp  = '0;
      assign lge = 1'b1;
    end else begin : g_body
      assign lv  = cell_valid[i-1];
      assign lt  = cell_tag[i-1];
      assign lp  = cell_prio[i-1];
      assign lge = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rv = 1'b0;
      assign rt = '0;
      assign rp = '0;
    end else begin : g_inner
      assign rv = cell_valid[i+1];
      assign rt = cell_tag[i+1];
      assign rp = cell_prio[i+1];
    end

    spq_cell #(
      .TAG_BITS  (TAG_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_tag_i     (req_tag),
      .new_prio_i    (req_prio),
      .left_valid_i  (lv),
      .left_tag_i    (lt),
      .left_prio_i   (lp),
      .left_ge_i     (lge),
      .right_valid_i (rv),
      .right_tag_i   (rt),
      .right_prio_i  (rp),
      .del_i         (del[i]),
      .valid_o       (cell_valid[i]),
      .tag_o         (cell_tag[i]),
      .prio_o        (cell_prio[i]),
      .ge_o          (cell_ge[i]),
      .match_o       (cell_match[i])
    );
  end

  spq_first_match #(
    .N (CAPACITY)
  ) u_first_match (
    .match_i (cell_match),
    .incl_o  (del),
    .first_o (first)
  );

  always_comb begin
    rm_prio = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rm_prio = rm_prio | (first[i] ? cell_prio[i] : '0);
    end
  end

  // row control, response and occupancy
  always_comb begin
    ctrl.mode    = mode;
    ctrl.en      = 1'b0;
    occ_d        = occ_q;
    rsp_tag_d    = '0;
    rsp_prio_d   = '0;
    rsp_status_d = spq_pkg::StatusOk;
    case (mode)
      spq_pkg::ModeEnqueue: begin
        if (full) begin
          rsp_status_d = spq_pkg::StatusFull;
          rsp_tag_d    = cell_tag[0];
          rsp_prio_d   = cell_prio[0];
        end else begin
          ctrl.en = accept;
          occ_d   = occ_q + OccBits'(1);
          if (!cell_ge[0]) begin
            rsp_tag_d  = req_tag;
            rsp_prio_d = req_prio;
          end else begin
            rsp_tag_d  = cell_tag[0];
            rsp_prio_d = cell_prio[0];
          end
        end
      end
      spq_pkg::ModePop: begin
        if (empty) begin
          rsp_status_d = spq_pkg::StatusEmpty;
        end else begin
          ctrl.en    = accept;
          occ_d      = occ_q - OccBits'(1);
          rsp_tag_d  = cell_tag[0];
          rsp_prio_d = cell_prio[0];
        end
      end
      spq_pkg::ModeRemove: begin
        if (empty) begin
          rsp_status_d = spq_pkg::StatusEmpty;
        end else if (!found) begin
          rsp_status_d = spq_pkg::StatusNotFound;
        end else begin
          ctrl.en    = accept;
          occ_d      = occ_q - OccBits'(1);
          rsp_tag_d  = req_tag;
          rsp_prio_d = rm_prio;
        end
      end
      spq_pkg::ModePeek: begin
        if (empty) begin
          rsp_status_d = spq_pkg::StatusEmpty;
        end else begin
          rsp_tag_d  = cell_tag[0];
          rsp_prio_d = cell_prio[0];
        end
      end
      default: begin
      end
    endcase
  end

  assign occ_ext = {{CntBits{1'b0}}, occ_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        occ_q <= occ_d;
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_tag_q    <= rsp_tag_d;
      rsp_prio_q   <= rsp_prio_d;
      rsp_status_q <= rsp_status_d;
      rsp_count_q  <= occ_ext[CntBits-1:0];
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.out_tag      = rsp_tag_q;
  assign rsp_o.out_priority = rsp_prio_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.count        = rsp_count_q;

endmodule

/* src/spq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted row: holds an entry, compares it against the
// request and loads itself from the request or from a neighbor
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned TAG_BITS  = spq_pkg::TagBits,
  parameter int unsigned PRIO_BITS = spq_pkg::PrioBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spq_pkg::cell_ctrl_t         ctrl_i,
  input  logic [TAG_BITS-1:0]         new_tag_i,
  input  logic signed [PRIO_BITS-1:0] new_prio_i,
  input  logic                        left_valid_i,
  input  logic [TAG_BITS-1:0]         left_tag_i,
  input  logic signed [PRIO_BITS-1:0] left_prio_i,
  input  logic                        left_ge_i,
  input  logic                        right_valid_i,
  input  logic [TAG_BITS-1:0]         right_tag_i,
  input  logic signed [PRIO_BITS-1:0] right_prio_i,
  input  logic                        del_i,
  output logic                        valid_o,
  output logic [TAG_BITS-1:0]         tag_o,
  output logic signed [PRIO_BITS-1:0] prio_o,
  output logic                        ge_o,
  output logic                        match_o
);

  logic                        valid_q, valid_d;
  logic [TAG_BITS-1:0]         tag_q, tag_d;
  logic signed [PRIO_BITS-1:0] prio_q, prio_d;

  assign ge_o    = valid_q && (prio_q >= new_prio_i);
  assign match_o = valid_q && (tag_q == new_tag_i);

  always_comb begin
    valid_d = valid_q;
    tag_d   = tag_q;
    prio_d  = prio_q;
    if (ctrl_i.en) begin
      case (ctrl_i.mode)
        spq_pkg::ModeEnqueue: begin
          if (!ge_o) begin
            if (left_ge_i) begin
              valid_d = 1'b1;
              tag_d   = new_tag_i;
              prio_d  = new_prio_i;
            end else begin
              valid_d = left_valid_i;
              tag_d   = left_tag_i;
              prio_d  = left_prio_i;
            end
          end
        end
        spq_pkg::ModePop: begin
          valid_d = right_valid_i;
          tag_d   = right_tag_i;
          prio_d  = right_prio_i;
        end
        spq_pkg::ModeRemove: begin
          if (del_i) begin
            valid_d = right_valid_i;
            tag_d   = right_tag_i;
            prio_d  = right_prio_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    prio_q <= prio_d;
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign prio_o  = prio_q;

endmodule

/* src/spq_first_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_first_match
// log-depth prefix or over the tag match flags of the row, giving the
// cells at or behind the first match and the first match itself
// ----------------------------------------------------------------------------
module spq_first_match #(
  parameter int unsigned N = spq_pkg::Capacity
) (
  input  logic [N-1:0] match_i,
  output logic [N-1:0] incl_o,
  output logic [N-1:0] first_o
);

  localparam int unsigned Levels = $clog2(N);

  logic [N-1:0] lvl [Levels+1];

  always_comb begin
    lvl[0] = match_i;
    for (int l = 0; l < Levels; l++) begin
      for (int i = 0; i < N; i++) begin
        if (i >= (1 << l)) begin
          lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
        end else begin
          lvl[l+1][i] = lvl[l][i];
        end
      end
    end
  end

  assign incl_o  = lvl[Levels];
  assign first_o = match_i & ~{incl_o[N-2:0], 1'b0};

endmodule

/* sim/tb_sorted_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// self-checking bench for the sorted priority queue
// ----------------------------------------------------------------------------
// Requests come from a list that is built before reset: a directed opening
// (empty queue, extreme tags and priorities, ties, duplicate tags, a miss on
// remove, filling past capacity), then random traffic that swings between
// filling and draining phases. A bench-side copy of the queue predicts the
// response of every request transfer; responses are checked in order, field
// by field. Both channels idle at random, with one quiet stretch, and the
// response side holds off once for a long stretch so the request side stalls.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

  localparam int unsigned HoldCycles = 80;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned NumRandom  = 500;

  typedef struct packed {
    spq_pkg::mode_e                mode;
    logic [spq_pkg::TagBits-1:0]   tag;
    logic [spq_pkg::PrioBits-1:0]  prio;
  } req_t;

  typedef struct packed {
    logic [spq_pkg::TagBits-1:0]   tag;
    logic [spq_pkg::PrioBits-1:0]  prio;
    spq_pkg::status_e              status;
    logic [spq_pkg::CountBits-1:0] count;
  } rsp_t;

  typedef struct packed {
    logic [spq_pkg::Capacity-1:0][spq_pkg::TagBits-1:0]  tags;
    logic [spq_pkg::Capacity-1:0][spq_pkg::PrioBits-1:0] prios;
    logic [7:0]                                          held;
  } queue_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         req_valid = 1'b0;
  logic [1:0]                   req_mode = 2'b0;
  logic [spq_pkg::TagBits-1:0]  req_tag = '0;
  logic [spq_pkg::PrioBits-1:0] req_prio = '0;
  logic                         rsp_ready = 1'b0;

  logic req_fire = 1'b0;
  logic rsp_fire = 1'b0;

  req_t   pending_reqs[$];
  rsp_t   expected_rsps[$];
  queue_t planned_queue = '0;
  queue_t predicted_queue = '0;

  req_t seen_req;
  rsp_t want_rsp;
  rsp_t got_rsp;

  int reqs_taken = 0;
  int rsps_checked = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int hold_left = 0;
  bit hold_done = 1'b0;

  spq_in_if  req_if ();
  spq_out_if rsp_if ();

  assign req_if.valid        = req_valid;
  assign req_if.mode         = req_mode;
  assign req_if.tag          = req_tag;
  assign req_if.priority_req = req_prio;
  assign rsp_if.ready        = rsp_ready;

  sorted_priority_queue u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // one request applied to a copy of the queue; returns the updated queue
  function automatic queue_t queue_apply(input queue_t q, input req_t r, output rsp_t rsp);
    queue_t n;
    int     i;
    int     pos;
    bit     found;
    n = q;
    rsp = '0;
    pos = 0;
    found = 1'b0;
    if (r.mode == spq_pkg::ModeEnqueue) begin
      if (n.held >= spq_pkg::Capacity) begin
        rsp.status = spq_pkg::StatusFull;
      end else begin
        while (pos < n.held && $signed(n.prios[pos]) >= $signed(r.prio)) pos++;
        for (i = spq_pkg::Capacity - 1; i > pos; i--) begin
          n.tags[i]  = n.tags[i-1];
          n.prios[i] = n.prios[i-1];
        end
        n.tags[pos]  = r.tag;
        n.prios[pos] = r.prio;
        n.held++;
      end
      if (n.held != 0) begin
        rsp.tag  = n.tags[0];
        rsp.prio = n.prios[0];
      end
    end else if (n.held == 0) begin
      rsp.status = spq_pkg::StatusEmpty;
    end else if (r.mode == spq_pkg::ModePeek) begin
      rsp.tag  = n.tags[0];
      rsp.prio = n.prios[0];
    end else begin
      if (r.mode == spq_pkg::ModePop) begin
        found = 1'b1;
      end else begin
        for (i = 0; i < n.held; i++) begin
          if (!found && n.tags[i] == r.tag) begin
            found = 1'b1;
            pos = i;
          end
        end
      end
      if (found) begin
        rsp.tag  = n.tags[pos];
        rsp.prio = n.prios[pos];
        for (i = pos; i < spq_pkg::Capacity - 1; i++) begin
          n.tags[i]  = n.tags[i+1];
          n.prios[i] = n.prios[i+1];
        end
        n.held--;
      end else begin
        rsp.status = spq_pkg::StatusNotFound;
      end
    end
    rsp.count = n.held[spq_pkg::CountBits-1:0];
    return n;
  endfunction

  // queue a request and track the queue it will leave behind
  task automatic plan_req(input spq_pkg::mode_e m, input logic [spq_pkg::TagBits-1:0] t,
                          input logic [spq_pkg::PrioBits-1:0] p);
    req_t r;
    rsp_t unused;
    r.mode = m;
    r.tag  = t;
    r.prio = p;
    planned_queue = queue_apply(planned_queue, r, unused);
    pending_reqs.push_back(r);
  endtask

  function automatic bit quiet_stretch();
    return reqs_taken >= 250 && reqs_taken < 350;
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (pending_reqs.size() != 0 &&
          (quiet_stretch() || hold_left != 0 || $urandom_range(0, 99) >= 10)) begin
        seen_req = pending_reqs.pop_front();
        req_valid <= 1'b1;
        req_mode  <= seen_req.mode;
        req_tag   <= seen_req.tag;
        req_prio  <= seen_req.prio;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response ready, with one long hold-off to back up the queue
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && reqs_taken >= 40) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= quiet_stretch() || $urandom_range(0, 99) >= 10;
    end
  end

  // predict on request transfers, check on response transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_fire = req_if.valid && req_if.ready;
      rsp_fire = rsp_if.valid && rsp_ready;
      if (req_fire) begin
        seen_req.mode = spq_pkg::mode_e'(req_if.mode);
        seen_req.tag  = req_if.tag;
        seen_req.prio = req_if.priority_req;
        predicted_queue = queue_apply(predicted_queue, seen_req, want_rsp);
        expected_rsps.push_back(want_rsp);
        reqs_taken++;
      end
      if (rsp_fire) begin
        got_rsp.tag    = rsp_if.out_tag;
        got_rsp.prio   = rsp_if.out_priority;
        got_rsp.status = spq_pkg::status_e'(rsp_if.status);
        got_rsp.count  = rsp_if.count;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response tag %h prio %0d status %0d count %0d",
                   $time, got_rsp.tag, $signed(got_rsp.prio), got_rsp.status, got_rsp.count);
          mismatches++;
        end else begin
          want_rsp = expected_rsps.pop_front();
          status_seen[want_rsp.status]++;
          rsps_checked++;
          if (got_rsp.tag !== want_rsp.tag) begin
            $display("%0t: out_tag expected %h, got %h", $time, want_rsp.tag, got_rsp.tag);
            mismatches++;
          end
          if (got_rsp.prio !== want_rsp.prio) begin
            $display("%0t: out_priority expected %0d, got %0d", $time,
                     $signed(want_rsp.prio), $signed(got_rsp.prio));
            mismatches++;
          end
          if (got_rsp.status !== want_rsp.status) begin
            $display("%0t: status expected %0d, got %0d", $time,
                     want_rsp.status, got_rsp.status);
            mismatches++;
          end
          if (got_rsp.count !== want_rsp.count) begin
            $display("%0t: count expected %0d, got %0d", $time,
                     want_rsp.count, got_rsp.count);
            mismatches++;
          end
        end
      end
      if (req_fire || rsp_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int          i;
    int          enq_pct;
    int          pick;
    logic [15:0] prio;
    logic [31:0] tag;

    // empty queue
    plan_req(spq_pkg::ModePeek, 32'h0, 16'h0);
    plan_req(spq_pkg::ModePop, 32'hFFFF_FFFF, 16'h7FFF);
    plan_req(spq_pkg::ModeRemove, 32'h1234, 16'h8000);
    // extremes and ties
    plan_req(spq_pkg::ModeEnqueue, 32'hFFFF_FFFF, 16'h7FFF);
    plan_req(spq_pkg::ModeEnqueue, 32'h0, 16'h8000);
    plan_req(spq_pkg::ModeEnqueue, 32'hA5A5_A5A5, 16'h0);
    plan_req(spq_pkg::ModeEnqueue, 32'h5A5A_5A5A, 16'h0);
    plan_req(spq_pkg::ModeEnqueue, 32'h1234, 16'd100);
    plan_req(spq_pkg::ModeEnqueue, 32'h1234, -16'sd5);
    plan_req(spq_pkg::ModePeek, 32'h0, 16'h0);
    plan_req(spq_pkg::ModeRemove, 32'h5A5A_5A5A, 16'h0);
    plan_req(spq_pkg::ModeRemove, 32'h1234, 16'h0);
    plan_req(spq_pkg::ModeRemove, 32'hDEAD_BEEF, 16'h0);
    plan_req(spq_pkg::ModePop, 32'h0, 16'h0);
    // fill past capacity
    for (i = 0; i < 14; i++) plan_req(spq_pkg::ModeEnqueue, 32'(i), 16'(i % 3));

    for (i = 0; i < NumRandom; i++) begin
      enq_pct = ((i / 40) % 2 == 0) ? 65 : 25;
      if ($urandom_range(0, 3) == 0) begin
        tag = $urandom;
      end else begin
        tag = $urandom_range(0, 15);
      end
      case ($urandom_range(0, 3))
        0: prio = 16'($urandom);
        1: prio = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        default: prio = 16'($urandom_range(0, 6) - 3);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < enq_pct) begin
        plan_req(spq_pkg::ModeEnqueue, tag, prio);
      end else begin
        case ($urandom_range(0, 2))
          0: plan_req(spq_pkg::ModePop, tag, prio);
          1: begin
            if (planned_queue.held != 0 && $urandom_range(0, 3) != 0) begin
              tag = planned_queue.tags[$urandom_range(0, planned_queue.held - 1)];
            end
            plan_req(spq_pkg::ModeRemove, tag, prio);
          end
          default: plan_req(spq_pkg::ModePeek, tag, prio);
        endcase
      end
    end

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || req_valid) @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d requests checked: %0d ok, %0d on empty queue, %0d dropped as full,",
             rsps_checked, status_seen[spq_pkg::StatusOk],
             status_seen[spq_pkg::StatusEmpty], status_seen[spq_pkg::StatusFull]);
    $display("%0d removes missed; %0d field mismatches",
             status_seen[spq_pkg::StatusNotFound], mismatches);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
